>>> hdl/esort_pkg.sv
// Shared types and constants for the exchange sort engine.
`timescale 1ns / 1ps
`default_nettype none
package esort_pkg;

    localparam int unsigned MAX_ITEMS_DEF = 64;
    localparam int unsigned DATA_W        = 32;

    typedef struct packed {
        logic                     vld;
        logic signed [DATA_W-1:0] data;
    } t_link;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SETTLE,
        ST_DRAIN
    } t_state;

endpackage
`default_nettype wire

>>> hdl/esort_if.sv
// Valid/ready channels carrying input words and sorted result words.
`timescale 1ns / 1ps
`default_nettype none
interface esort_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [esort_pkg::DATA_W-1:0]   value;
    logic                                  last_item;

    modport source (output valid, output value, output last_item, input ready);
    modport sink   (input valid, input value, input last_item, output ready);
endinterface

interface esort_out_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [esort_pkg::DATA_W-1:0]   sorted_value;
    logic                                  last_result;
    logic                                  dropped;

    modport source (output valid, output sorted_value, output last_result, output dropped,
                    input ready);
    modport sink   (input valid, input sorted_value, input last_result, input dropped,
                    output ready);
endinterface
`default_nettype wire

>>> hdl/esort_cell.sv
// One insertion cell: keeps the smaller word, passes the larger one right, shifts left on drain.
`timescale 1ns / 1ps
`default_nettype none
module esort_cell (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_shift,
    input  wire esort_pkg::t_link i_left,
    input  wire esort_pkg::t_link i_right,
    output esort_pkg::t_link      o_pass,
    output esort_pkg::t_link      o_hold
);

    logic                                r_full;
    logic                                n_full;
    logic signed [esort_pkg::DATA_W-1:0] r_val;
    logic signed [esort_pkg::DATA_W-1:0] n_val;
    esort_pkg::t_link                    r_pass;
    esort_pkg::t_link                    n_pass;

    always_comb begin
        n_full      = r_full;
        n_val       = r_val;
        n_pass.vld  = 1'b0;
        n_pass.data = r_pass.data;
        if (i_shift) begin
            n_full = i_right.vld;
            n_val  = i_right.data;
        end else if (i_left.vld) begin
            if (!r_full) begin
                n_full = 1'b1;
                n_val  = i_left.data;
            end else if ($signed(i_left.data) < $signed(r_val)) begin
                n_val       = i_left.data;
                n_pass.vld  = 1'b1;
                n_pass.data = r_val;
            end else begin
                n_pass.vld  = 1'b1;
                n_pass.data = i_left.data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_full     <= 1'b0;
            r_pass.vld <= 1'b0;
        end else begin
            r_full     <= n_full;
            r_pass.vld <= n_pass.vld;
        end
        r_val       <= n_val;
        r_pass.data <= n_pass.data;
    end

    assign o_pass = r_pass;
    assign o_hold = '{vld: r_full, data: r_val};

endmodule
`default_nettype wire

>>> hdl/exchange_sort_engine.sv
// After the last word the engine settles until no cell still passes a word, then drains results.
// Throughput: one input word per cycle while loading; one result word per cycle on drain while the sink is ready.
// A run is loaded, settles in the insertion chain and is then drained in ascending order.
// Settle time is set by the insertion chain: a word moves one cell per cycle.
// Reset is synchronous, active low; it empties the chain and clears count and drop flag.
`timescale 1ns / 1ps
`default_nettype none
module exchange_sort_engine #(
    parameter int unsigned MAX_ITEMS = esort_pkg::MAX_ITEMS_DEF
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    esort_in_if.sink   i_in,
    esort_out_if.source o_out
);

    localparam int unsigned CW = $clog2(MAX_ITEMS + 1);

    esort_pkg::t_state r_state;
    esort_pkg::t_state n_state;
    logic [CW-1:0]     r_count;
    logic [CW-1:0]     n_count;
    logic              r_ovf;
    logic              n_ovf;

    logic                                r_o_valid;
    logic                                n_o_valid;
    logic signed [esort_pkg::DATA_W-1:0] r_o_data;
    logic                                r_o_last;
    logic                                r_o_drop;

    logic in_ready;
    logic in_acc;
    logic store_full;
    logic out_free;
    logic do_shift;
    logic busy;

    esort_pkg::t_link      cell_left [MAX_ITEMS];
    esort_pkg::t_link      cell_right[MAX_ITEMS];
    esort_pkg::t_link      cell_pass [MAX_ITEMS];
    esort_pkg::t_link      cell_hold [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]  pass_vld;

    assign in_acc     = i_in.valid & in_ready;
    assign store_full = (r_count == CW'(MAX_ITEMS));
    assign out_free   = !r_o_valid | o_out.ready;
    assign busy       = |pass_vld;

    genvar g;
    generate
        for (g = 0; g < MAX_ITEMS; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_left[g] = '{vld: in_acc & !store_full, data: i_in.value};
            end else begin : g_body
                assign cell_left[g] = cell_pass[g-1];
            end
            if (g == MAX_ITEMS - 1) begin : g_tail
                assign cell_right[g] = '0;
            end else begin : g_mid
                assign cell_right[g] = cell_hold[g+1];
            end
            assign pass_vld[g] = cell_pass[g].vld;

            esort_cell u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (do_shift),
                .i_left  (cell_left[g]),
                .i_right (cell_right[g]),
                .o_pass  (cell_pass[g]),
                .o_hold  (cell_hold[g])
            );
        end
    endgenerate

    always_comb begin
        n_state = r_state;
        case (r_state)
            esort_pkg::ST_LOAD: begin
                if (in_acc && i_in.last_item) n_state = esort_pkg::ST_SETTLE;
            end
            esort_pkg::ST_SETTLE: begin
                if (!busy) n_state = esort_pkg::ST_DRAIN;
            end
            esort_pkg::ST_DRAIN: begin
                if (r_count == '0 || (do_shift && r_count == CW'(1))) begin
                    n_state = esort_pkg::ST_LOAD;
                end
            end
            default: n_state = esort_pkg::ST_LOAD;
        endcase
    end

    always_comb begin
        in_ready = 1'b0;
        do_shift = 1'b0;
        case (r_state)
            esort_pkg::ST_LOAD:   in_ready = 1'b1;
            esort_pkg::ST_SETTLE: ;
            esort_pkg::ST_DRAIN:  do_shift = out_free & (r_count != '0);
            default: ;
        endcase
    end

    always_comb begin
        n_count   = r_count;
        n_ovf     = r_ovf;
        n_o_valid = r_o_valid & !o_out.ready;
        if (in_acc) begin
            if (store_full) begin
                n_ovf = 1'b1;
            end else begin
                n_count = r_count + CW'(1);
            end
        end
        if (do_shift) begin
            n_count   = r_count - CW'(1);
            n_o_valid = 1'b1;
            if (r_count == CW'(1)) n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= esort_pkg::ST_LOAD;
            r_count   <= '0;
            r_ovf     <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_ovf     <= n_ovf;
            r_o_valid <= n_o_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_shift) begin
            r_o_data <= cell_hold[0].data;
            r_o_last <= (r_count == CW'(1));
            r_o_drop <= r_ovf;
        end
    end

    assign i_in.ready          = in_ready;
    assign o_out.valid         = r_o_valid;
    assign o_out.sorted_value  = r_o_data;
    assign o_out.last_result   = r_o_last;
    assign o_out.dropped       = r_o_drop;

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(MAX_ITEMS))
        else $error("stored word count exceeds capacity");

    a_tail_no_spill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !cell_pass[MAX_ITEMS-1].vld)
        else $error("word pushed out of the last cell");

    a_shift_full_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_shift |-> cell_hold[0].vld)
        else $error("drain shift from an empty head cell");

    a_empty_after_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_shift && r_count == CW'(1)) |=> (!cell_hold[0].vld && r_state == esort_pkg::ST_LOAD))
        else $error("chain not empty after final result");
`endif

endmodule
`default_nettype wire

>>> dv/exchange_sort_engine_checker.sv
// Checker for the exchange sort engine: predicts each sorted run and compares result words.
`timescale 1ns / 1ps
module exchange_sort_engine_checker #(
    parameter int unsigned MAX_ITEMS = esort_pkg::MAX_ITEMS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic signed [esort_pkg::DATA_W-1:0] i_in_value,
    input  logic                                i_in_last,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [esort_pkg::DATA_W-1:0] i_out_value,
    input  logic                                i_out_last,
    input  logic                                i_out_dropped,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_words,
    output int                                  o_runs,
    output int                                  o_results,
    output int                                  o_drop_runs
);

    typedef struct packed {
        logic signed [esort_pkg::DATA_W-1:0] value;
        logic                                last;
        logic                                dropped;
    } t_sorted_word;

    logic signed [esort_pkg::DATA_W-1:0] run_store [MAX_ITEMS];
    int                                  run_count;
    logic                                run_overflow;
    t_sorted_word                        sorted_q [$];

    task automatic report_mismatch(input string what);
        o_fail_count++;
        $display("[%0t] result %0d: %s", $time, o_results, what);
    endtask

    task automatic absorb_word(input logic signed [esort_pkg::DATA_W-1:0] value);
        if (run_count < MAX_ITEMS) begin
            run_store[run_count] = value;
            run_count++;
        end else begin
            run_overflow = 1'b1;
        end
    endtask

    task automatic close_run();
        logic signed [esort_pkg::DATA_W-1:0] vals [MAX_ITEMS];
        logic signed [esort_pkg::DATA_W-1:0] tmp;
        t_sorted_word                        w;
        for (int i = 0; i < run_count; i++) vals[i] = run_store[i];
        for (int i = 0; i < run_count; i++) begin
            for (int j = i + 1; j < run_count; j++) begin
                if (vals[i] > vals[j]) begin
                    tmp     = vals[i];
                    vals[i] = vals[j];
                    vals[j] = tmp;
                end
            end
        end
        for (int k = 0; k < run_count; k++) begin
            w.value   = vals[k];
            w.last    = (k == run_count - 1);
            w.dropped = run_overflow;
            sorted_q.push_back(w);
        end
        o_runs++;
        if (run_overflow) o_drop_runs++;
        run_count    = 0;
        run_overflow = 1'b0;
    endtask

    always @(posedge i_clk) begin
        t_sorted_word want;
        if (!i_rst_n) begin
            run_count    = 0;
            run_overflow = 1'b0;
            sorted_q.delete();
        end else begin
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (sorted_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected word value %0d", i_out_value));
                end else begin
                    want = sorted_q.pop_front();
                    if (i_out_value !== want.value)
                        report_mismatch($sformatf("sorted_value %0d, want %0d",
                                                  i_out_value, want.value));
                    if (i_out_last !== want.last)
                        report_mismatch($sformatf("last_result %b, want %b",
                                                  i_out_last, want.last));
                    if (i_out_dropped !== want.dropped)
                        report_mismatch($sformatf("dropped %b, want %b",
                                                  i_out_dropped, want.dropped));
                end
            end
            if (i_in_valid && i_in_ready) begin
                o_words++;
                absorb_word(i_in_value);
                if (i_in_last) close_run();
            end
        end
        o_pending = sorted_q.size();
    end

endmodule

>>> dv/exchange_sort_engine_tb.sv
// Top of the exchange sort engine testbench: clock, reset, word stimulus and verdict.
`timescale 1ns / 1ps
module exchange_sort_engine_tb;

    localparam int CAP            = esort_pkg::MAX_ITEMS_DEF;
    localparam int ITEMS          = 260;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DIR_N          = 22;

    localparam logic signed [esort_pkg::DATA_W-1:0] DIR_VALUE [DIR_N] = '{
        32'h7fffffff,
        32'h80000000,
        32'h7fffffff, 32'h00000001, 32'h00000000, 32'hffffffff, 32'h80000000,
        32'h00000005, 32'h00000005, 32'hfffffffd, 32'h00000005, 32'hfffffffd,
        32'h55555555, 32'haaaaaaaa, 32'hffffffff, 32'h00000000, 32'h80000001,
        32'hfffffffe, 32'hffffffff, 32'h00000000, 32'h00000001, 32'h00000002
    };
    localparam logic [DIR_N-1:0] DIR_LAST = 22'h210843;

    logic i_clk;
    logic i_rst_n;
    int   src_idle_pct;
    int   snk_idle_pct;
    int   idle_cycles;
    logic signed [esort_pkg::DATA_W-1:0] prev_value;

    int fail_count;
    int pending;
    int words;
    int runs;
    int results;
    int drop_runs;

    esort_in_if  in_ch ();
    esort_out_if out_ch ();

    exchange_sort_engine #(
        .MAX_ITEMS(CAP)
    ) dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch),
        .o_out  (out_ch)
    );

    exchange_sort_engine_checker #(
        .MAX_ITEMS(CAP)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (in_ch.valid),
        .i_in_ready   (in_ch.ready),
        .i_in_value   (in_ch.value),
        .i_in_last    (in_ch.last_item),
        .i_out_valid  (out_ch.valid),
        .i_out_ready  (out_ch.ready),
        .i_out_value  (out_ch.sorted_value),
        .i_out_last   (out_ch.last_result),
        .i_out_dropped(out_ch.dropped),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_words      (words),
        .o_runs       (runs),
        .o_results    (results),
        .o_drop_runs  (drop_runs)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("no word moved for %0d cycles, %0d results outstanding",
                     idle_cycles, pending);
            $display("exchange_sort_engine: mismatch");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic signed [esort_pkg::DATA_W-1:0] pick_value(
        input logic signed [esort_pkg::DATA_W-1:0] prev
    );
        logic signed [esort_pkg::DATA_W-1:0] v;
        case ($urandom_range(7))
            0: begin
                case ($urandom_range(4))
                    0:       v = {1'b1, {(esort_pkg::DATA_W-1){1'b0}}};
                    1:       v = {1'b0, {(esort_pkg::DATA_W-1){1'b1}}};
                    2:       v = '0;
                    3:       v = '1;
                    default: v = 1;
                endcase
            end
            1:       v = prev;
            2:       v = $signed($urandom_range(20)) - 10;
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_word(input logic signed [esort_pkg::DATA_W-1:0] value, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.value     <= value;
        in_ch.last_item <= last;
        do @(posedge i_clk); while (!in_ch.ready);
    endtask

    task automatic send_run(input int len);
        logic signed [esort_pkg::DATA_W-1:0] v;
        for (int i = 0; i < len; i++) begin
            v          = pick_value(prev_value);
            prev_value = v;
            send_word(v, i == len - 1);
        end
    endtask

    // hold the sender until every predicted word has drained
    task automatic wait_for_results();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        @(posedge i_clk);
    endtask

    initial begin
        int budget;
        int sent;
        int len;
        i_rst_n         <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.value     <= '0;
        in_ch.last_item <= 1'b0;
        src_idle_pct = 10;
        snk_idle_pct = 53;
        prev_value   = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < DIR_N; k++) send_word(DIR_VALUE[k], DIR_LAST[k]);

        budget = (ITEMS - DIR_N) / 3;
        for (int phase = 0; phase < 3; phase++) begin
            src_idle_pct = (phase == 0) ? 10 : (phase == 1) ? 53 : 0;
            snk_idle_pct = (phase == 0) ? 53 : (phase == 1) ? 10 : 0;
            wait_for_results();
            sent = 0;
            // fill the store exactly, then overrun it including the closing word
            if (phase == 0) begin
                send_run(CAP);
                sent += CAP;
            end else if (phase == 2) begin
                send_run(CAP + 2);
                sent += CAP + 2;
            end
            while (sent < budget) begin
                len = ($urandom_range(7) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
                send_run(len);
                sent += len;
            end
        end

        wait_for_results();
        repeat (CAP + 8) @(posedge i_clk);

        $display("covered %0d words in %0d runs, %0d sorted words checked, %0d runs over capacity",
                 words, runs, results, drop_runs);
        $display("stalls swept on both channels, then a stretch with no stalls");
        if (fail_count == 0 && pending == 0) begin
            $display("exchange_sort_engine: match");
        end else begin
            $display("exchange_sort_engine: mismatch");
        end
        $finish;
    end

endmodule
